[hdl/pida_pkg.sv]
package pida_pkg;

   localparam int PID_W    = 9;
   // identifiers run 1..ID_LIMIT-1, zero is the idle process
   localparam int ID_LIMIT = 1 << PID_W;
   localparam int BOUND_W  = PID_W + 1;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_LOOKUP  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PASS,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic             set;
      logic             clr;
      logic [PID_W-1:0] id;
   } tbl_wr_type;

   typedef struct packed {
      logic             vld;
      logic [PID_W-1:0] id;
   } tbl_entry_type;

   typedef struct packed {
      logic             best_found;
      logic [PID_W-1:0] best_id;
      logic             free_found;
   } scan_res_type;

endpackage

[hdl/process_id_allocator_unit.sv]
// channel | direction | tdata fields, lowest bit up            | handshake
// req     | in        | cmd[1:0], pid_in[10:2], zero [15:11]     | req_tvalid / req_tready
// rsp     | out       | status[1:0], pid_out[10:2], zero [15:11] | rsp_tvalid / rsp_tready
//
// every request but those below runs at least one pass over the MAX_ENTRIES table
// slots through a single compare unit; an allocate that must skip live ids in a row
// runs one further pass for each live id that it skips.
// an allocate on a full table and a release or lookup of id zero answer without a pass.
// reset (synchronous) clears every slot's valid bit at once, no clearing pass.
// req_tready is high only between requests; one result may wait in the output
// register while the next word is being worked on.
module process_id_allocator_unit #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pida_pkg::REQ_W-1:0] req_tdata,   // cmd, pid_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pida_pkg::RSP_W-1:0] rsp_tdata    // status, pid_out
);
   import pida_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);

   logic             scan_start;
   logic [PID_W-1:0] scan_key;
   logic             scan_done;
   scan_res_type     scan_res;
   logic [AW-1:0]    best_slot;
   logic [AW-1:0]    free_slot;
   logic [AW-1:0]    rd_addr;
   tbl_entry_type    rd_entry;
   tbl_wr_type       tbl_wr;
   logic [AW-1:0]    wr_slot;

   pida_table #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .wr_slot  (wr_slot),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   pida_scan #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .key       (scan_key),
      .rd_entry  (rd_entry),
      .rd_addr   (rd_addr),
      .done      (scan_done),
      .res       (scan_res),
      .best_slot (best_slot),
      .free_slot (free_slot)
   );

   pida_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .scan_start (scan_start),
      .scan_key   (scan_key),
      .scan_done  (scan_done),
      .scan_res   (scan_res),
      .best_slot  (best_slot),
      .free_slot  (free_slot),
      .tbl_wr     (tbl_wr),
      .wr_slot    (wr_slot)
   );

endmodule

[hdl/pida_table.sv]
module pida_table #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pida_pkg::tbl_wr_type           wr,
   input  logic [$clog2(MAX_ENTRIES)-1:0] wr_slot,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output pida_pkg::tbl_entry_type        rd_entry
);
   import pida_pkg::*;

   logic [PID_W-1:0]       mem_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [PID_W-1:0]       rd_id_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.set) begin
         mem_ff[wr_slot] <= wr.id;
      end
      rd_id_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.set) begin
            valid_ff[wr_slot] <= 1'b1;
         end else if (wr.clr) begin
            valid_ff[wr_slot] <= 1'b0;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry.vld = rd_vld_ff;
   assign rd_entry.id  = rd_id_ff;

endmodule

[hdl/pida_scan.sv]
module pida_scan #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pida_pkg::PID_W-1:0]     key,
   input  pida_pkg::tbl_entry_type        rd_entry,
   output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output logic                           done,
   output pida_pkg::scan_res_type         res,
   output logic [$clog2(MAX_ENTRIES)-1:0] best_slot,
   output logic [$clog2(MAX_ENTRIES)-1:0] free_slot
);
   import pida_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);

   logic             run_ff;
   logic [AW-1:0]    addr_ff;
   logic             pend_ff;
   logic             pend_last_ff;
   logic [AW-1:0]    slot_d_ff;
   logic             done_ff;
   logic             best_found_ff;
   logic [PID_W-1:0] best_id_ff;
   logic [AW-1:0]    best_slot_ff;
   logic             free_found_ff;
   logic [AW-1:0]    free_slot_ff;
   logic             at_end;
   logic             take_best;

   assign at_end = (addr_ff == AW'(MAX_ENTRIES - 1));

   // smallest live id at or above the key, first slot on a tie
   assign take_best = pend_ff && rd_entry.vld && (rd_entry.id >= key)
                      && (!best_found_ff || (rd_entry.id < best_id_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         pend_last_ff  <= 1'b0;
         done_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         pend_ff      <= run_ff;
         pend_last_ff <= run_ff && at_end;
         done_ff      <= pend_ff && pend_last_ff;
         if (start) begin
            run_ff        <= 1'b1;
            best_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (run_ff && at_end) begin
               run_ff <= 1'b0;
            end
            if (take_best) begin
               best_found_ff <= 1'b1;
            end
            if (pend_ff && !rd_entry.vld) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_d_ff <= addr_ff;
      if (start) begin
         addr_ff <= '0;
      end else if (run_ff) begin
         addr_ff <= addr_ff + AW'(1);
      end
      if (!start && take_best) begin
         best_id_ff   <= rd_entry.id;
         best_slot_ff <= slot_d_ff;
      end
      if (!start && pend_ff && !rd_entry.vld && !free_found_ff) begin
         free_slot_ff <= slot_d_ff;
      end
   end

   assign rd_addr        = addr_ff;
   assign done           = done_ff;
   assign res.best_found = best_found_ff;
   assign res.best_id    = best_id_ff;
   assign res.free_found = free_found_ff;
   assign best_slot      = best_slot_ff;
   assign free_slot      = free_slot_ff;

endmodule

[hdl/pida_ctrl.sv]
module pida_ctrl #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pida_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pida_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                           scan_start,
   output logic [pida_pkg::PID_W-1:0]     scan_key,
   input  logic                           scan_done,
   input  pida_pkg::scan_res_type         scan_res,
   input  logic [$clog2(MAX_ENTRIES)-1:0] best_slot,
   input  logic [$clog2(MAX_ENTRIES)-1:0] free_slot,
   output pida_pkg::tbl_wr_type           tbl_wr,
   output logic [$clog2(MAX_ENTRIES)-1:0] wr_slot
);
   import pida_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PID_W-1:0]    key_ff, key_in;
   logic                need_ff, need_in;
   logic [PID_W-1:0]    tries_ff, tries_in;
   logic [BOUND_W-1:0]  last_given_ff, last_given_in;
   logic [BOUND_W-1:0]  safe_bound_ff, safe_bound_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0] st_status_ff, st_status_in;
   logic [PID_W-1:0]    st_pid_ff, st_pid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PID_W-1:0]    rsp_pid_ff, rsp_pid_in;

   logic [CMD_W-1:0]    req_cmd;
   logic [PID_W-1:0]    req_pid;
   logic [BOUND_W-1:0]  cand;
   logic                hit;

   assign req_cmd = req_tdata[CMD_W-1:0];
   assign req_pid = req_tdata[CMD_W+PID_W-1:CMD_W];
   assign cand    = last_given_ff + BOUND_W'(1);
   assign hit     = scan_res.best_found && (scan_res.best_id == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_given_ff <= BOUND_W'(ID_LIMIT);
         safe_bound_ff <= BOUND_W'(ID_LIMIT);
         count_ff      <= CW'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_given_ff <= last_given_in;
         safe_bound_ff <= safe_bound_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      need_ff       <= need_in;
      tries_ff      <= tries_in;
      st_status_ff  <= st_status_in;
      st_pid_ff     <= st_pid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      need_in       = need_ff;
      tries_in      = tries_ff;
      last_given_in = last_given_ff;
      safe_bound_in = safe_bound_ff;
      count_in      = count_ff;
      st_status_in  = st_status_ff;
      st_pid_in     = st_pid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      req_tready    = 1'b0;
      scan_start    = 1'b0;
      tbl_wr        = '0;
      wr_slot       = free_slot;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = req_cmd;
               tries_in = '0;
               if (req_cmd == CMD_ALLOC) begin
                  if (count_ff >= CW'(MAX_ENTRIES)) begin
                     st_status_in = STATUS_FULL;
                     st_pid_in    = '0;
                     state_in     = S_REPLY;
                  end else begin
                     need_in    = (cand >= BOUND_W'(ID_LIMIT)) || (cand >= safe_bound_ff);
                     key_in     = (cand >= BOUND_W'(ID_LIMIT)) ? PID_W'(1)
                                                               : cand[PID_W-1:0];
                     scan_start = 1'b1;
                     state_in   = S_PASS;
                  end
               end else if (req_pid == '0) begin
                  st_status_in = STATUS_RANGE;
                  st_pid_in    = req_pid;
                  state_in     = S_REPLY;
               end else begin
                  key_in     = req_pid;
                  scan_start = 1'b1;
                  state_in   = S_PASS;
               end
            end
         end

         S_PASS: begin
            if (scan_done) begin
               if (cmd_ff != CMD_ALLOC) begin
                  st_pid_in = key_ff;
                  state_in  = S_REPLY;
                  if (hit) begin
                     st_status_in = STATUS_OK;
                     if (cmd_ff == CMD_RELEASE) begin
                        tbl_wr.clr = 1'b1;
                        wr_slot    = best_slot;
                        if (count_ff != '0) begin
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end else begin
                     st_status_in = STATUS_NOT_FOUND;
                  end
               end else if (!scan_res.free_found) begin
                  st_status_in = STATUS_FULL;
                  st_pid_in    = '0;
                  state_in     = S_REPLY;
               end else if (need_ff && hit) begin
                  // key taken, step on cyclically, pass again or reply full
                  if (tries_ff == PID_W'(ID_LIMIT - 2)) begin
                     st_status_in = STATUS_FULL;
                     st_pid_in    = '0;
                     state_in     = S_REPLY;
                  end else begin
                     tries_in   = tries_ff + PID_W'(1);
                     key_in     = (key_ff == PID_W'(ID_LIMIT - 1)) ? PID_W'(1)
                                                                  : key_ff + PID_W'(1);
                     scan_start = 1'b1;
                  end
               end else begin
                  tbl_wr.set    = 1'b1;
                  tbl_wr.id     = key_ff;
                  count_in      = count_ff + CW'(1);
                  last_given_in = {1'b0, key_ff};
                  if (need_ff) begin
                     safe_bound_in = scan_res.best_found ? {1'b0, scan_res.best_id}
                                                         : BOUND_W'(ID_LIMIT);
                  end
                  st_status_in = STATUS_OK;
                  st_pid_in    = key_ff;
                  state_in     = S_REPLY;
               end
            end
         end

         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_status_ff;
               rsp_pid_in    = st_pid_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign scan_key   = key_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - STATUS_W - PID_W)'(0), rsp_pid_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(MAX_ENTRIES)) && (count_ff != '0))
      else $error("live count outside its range");

   a_alloc_nonzero: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.set |-> (tbl_wr.id != '0))
      else $error("idle process id handed out");

   a_write_at_pass_end: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr.set || tbl_wr.clr) |-> (state_ff == S_PASS) && scan_done)
      else $error("table written outside the end of a pass");

   a_done_in_pass: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == S_PASS))
      else $error("scan finished while no pass was expected");

   a_bound_above_last: assert property (@(posedge clock) disable iff (reset)
      $past(tbl_wr.set) && $past(need_ff) |-> (safe_bound_ff > last_given_ff))
      else $error("safe bound not above the new id");
`endif

endmodule

[tb/sv/tb_process_id_allocator_unit.sv]
`timescale 1ns / 100ps

module tb_process_id_allocator_unit;
   import pida_pkg::*;

   localparam int ENTRIES = 256;
   // unused command code, the block treats it as a lookup
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int ITEM_GOAL = 1450;
   localparam int LONG_HOLD = 3000;
   localparam int TAIL_CYCLES = 2 * ENTRIES + 40;

   typedef struct packed {
      status_type       status;
      logic [PID_W-1:0] pid;
   } reply_type;

   class pid_table_model;
      bit              live [ID_LIMIT];
      int unsigned     live_count = 1;          // idle process holds id zero
      int unsigned     last_given = ID_LIMIT;
      int unsigned     safe_bound = ID_LIMIT;
      reply_type       pending_replies [$];
      int unsigned     error_count = 0;
      longint unsigned work_budget = 0;
      int unsigned     status_seen [4];
      int unsigned     wraps = 0;
      int unsigned     max_skip = 0;

      function reply_type grant_id();
         reply_type   r;
         int unsigned cand;
         int unsigned skipped;
         bit          found;
         r.status = STATUS_FULL;
         r.pid = '0;
         skipped = 0;
         if (live_count >= ENTRIES) begin
            work_budget += 2;
            return r;
         end
         cand = last_given + 1;
         // ids between last_given and safe_bound are known free, no search needed
         if (cand >= ID_LIMIT || cand >= safe_bound) begin
            if (cand >= ID_LIMIT) begin
               cand = 1;
               wraps++;
            end
            found = 1'b0;
            for (int n = 0; n + 1 < ID_LIMIT; n++) begin
               if (!live[cand]) begin
                  found = 1'b1;
                  break;
               end
               skipped++;
               cand++;
               if (cand >= ID_LIMIT) begin
                  cand = 1;
                  wraps++;
               end
            end
            if (!found) begin
               work_budget += ID_LIMIT * (ENTRIES + 3);
               return r;
            end
            safe_bound = ID_LIMIT;
            for (int id = cand + 1; id < ID_LIMIT; id++) begin
               if (live[id]) begin
                  safe_bound = id;
                  break;
               end
            end
         end
         if (skipped > max_skip) max_skip = skipped;
         work_budget += (skipped + 1) * (ENTRIES + 3) + 2;
         live[cand] = 1'b1;
         live_count++;
         last_given = cand;
         r.status = STATUS_OK;
         r.pid = cand[PID_W-1:0];
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid);
         reply_type r;
         r.pid = pid;
         work_budget += 200;
         if (cmd == CMD_ALLOC) begin
            r = grant_id();
         end else begin
            work_budget += ENTRIES + 5;
            if (pid == '0) begin
               r.status = STATUS_RANGE;
            end else if (!live[pid]) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               r.status = STATUS_OK;
               if (cmd == CMD_RELEASE) begin
                  live[pid] = 1'b0;
                  live_count--;
               end
            end
         end
         status_seen[r.status]++;
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [RSP_W-1:0] word);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, word);
            error_count++;
            return;
         end
         want = pending_replies.pop_front();
         if (word[STATUS_W-1:0] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, word[STATUS_W-1:0]);
            error_count++;
         end
         if (word[STATUS_W +: PID_W] !== want.pid) begin
            $display("%0t: pid mismatch, expected %0d, actual %0d", $time,
                     want.pid, word[STATUS_W +: PID_W]);
            error_count++;
         end
         if (word[RSP_W-1:STATUS_W+PID_W] !== '0) begin
            $display("%0t: padding mismatch, expected 0, actual %h", $time,
                     word[RSP_W-1:STATUS_W+PID_W]);
            error_count++;
         end
      endfunction

      function logic [PID_W-1:0] some_live_id();
         int unsigned id;
         id = $urandom_range(1, ID_LIMIT - 1);
         repeat (ID_LIMIT) begin
            if (live[id]) return id[PID_W-1:0];
            id = (id == ID_LIMIT - 1) ? 1 : id + 1;
         end
         // nothing live, the id comes back not found
         return id[PID_W-1:0];
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // cmd, pid_in, zero fill
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // status, pid_out, zero fill

   pid_table_model table_model = new();
   int  words_sent = 0;
   bit  calm = 1'b0;
   bit  hold_request = 1'b0;

   process_id_allocator_unit #(
      .MAX_ENTRIES(ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [PID_W-1:0] random_pid();
      return PID_W'($urandom_range(0, ID_LIMIT - 1));
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - CMD_W - PID_W){1'b0}}, pid, cmd};
      do @(posedge clock); while (!req_tready);
      table_model.note_request(cmd, pid);
      words_sent++;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_model.pending_replies.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) table_model.check_reply(rsp_tdata);
   end

   initial begin : receiver
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      longint unsigned cycles;
      cycles = 0;
      while (cycles <= 4 * table_model.work_budget + 200000) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timed out after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int target;
      int phase_left;
      int roll;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: id zero, unknown ids, spare command, alloc ignoring pid_in
      send_word(CMD_LOOKUP, '0);
      send_word(CMD_RELEASE, '0);
      send_word(CMD_ALLOC, 9'h1FF);
      send_word(CMD_ALLOC, '0);
      send_word(CMD_LOOKUP, 9'd1);
      send_word(CMD_LOOKUP, 9'h1FF);
      send_word(CMD_RELEASE, 9'h1FF);
      send_word(CMD_SPARE, 9'd2);
      send_word(CMD_SPARE, '0);
      send_word(CMD_RELEASE, 9'd2);
      send_word(CMD_RELEASE, 9'd2);
      send_word(CMD_LOOKUP, 9'd2);
      send_word(CMD_ALLOC, 9'h155);
      send_word(CMD_LOOKUP, 9'h0AA);
      send_word(CMD_RELEASE, 9'h155);
      send_word(CMD_ALLOC, 9'h0AA);
      send_word(CMD_RELEASE, 9'd1);

      // fill the table, then knock on it while full
      while (table_model.live_count < ENTRIES) begin
         if ($urandom_range(0, 9) == 0) send_word(CMD_LOOKUP, random_pid());
         else send_word(CMD_ALLOC, random_pid());
      end
      repeat (6) send_word(CMD_ALLOC, random_pid());
      send_word(CMD_LOOKUP, table_model.some_live_id());
      drain_replies();

      // receiver holds off while the sender keeps offering words
      hold_request = 1'b1;
      table_model.work_budget += LONG_HOLD;
      calm = 1'b1;
      target = 30;
      phase_left = 250;

      while (words_sent < ITEM_GOAL) begin
         if (phase_left == 0) begin
            target = ($urandom_range(0, 4) == 0) ? ENTRIES : $urandom_range(4, 120);
            phase_left = $urandom_range(60, 180);
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) drain_replies();
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_word(CMD_SPARE, random_pid());
         end else if (roll < 5) begin
            send_word(CMD_RELEASE, '0);
         end else if (roll < 6) begin
            send_word(CMD_LOOKUP, '0);
         end else if (roll < 9) begin
            send_word(CMD_RELEASE, random_pid());
         end else if (roll < 22) begin
            if ($urandom_range(0, 1) != 0) send_word(CMD_LOOKUP, table_model.some_live_id());
            else send_word(CMD_LOOKUP, random_pid());
         end else if ((table_model.live_count < target) == ($urandom_range(0, 99) < 80)) begin
            send_word(CMD_ALLOC, random_pid());
         end else begin
            send_word(CMD_RELEASE, table_model.some_live_id());
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_model.pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d ok, %0d refused full, %0d not found, %0d bad id",
               words_sent, table_model.status_seen[STATUS_OK],
               table_model.status_seen[STATUS_FULL],
               table_model.status_seen[STATUS_NOT_FOUND],
               table_model.status_seen[STATUS_RANGE]);
      $display("id search wrapped %0d times, longest run of live ids skipped %0d",
               table_model.wraps, table_model.max_skip);
      if (table_model.error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
